@@ src/cq_pkg.sv @@
package cq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] IDX_ZERO = '0;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // Value shown on both element outputs while the deque is empty.
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_REAR  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_REAR   = 3'd3,
    FUNC_REPORT     = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // request accepted this cycle: update pointers and store
    logic load_rd;  // read front and rear entries into the output registers
  } cmd_t;

endpackage

@@ src/circular_deque.sv @@
// Double-ended queue of cq_pkg::DEPTH signed 32-bit elements held in a
// circular store. Each request carries an operation code (push front, push
// rear, pop front, pop rear, or report only; unused codes act as report
// only) and a value that only pushes use. Every request returns exactly one
// response with the front and rear elements after the operation (both -1
// while the deque is empty), an empty flag, and a status: ok, overflow (a
// push into a full deque is dropped and the store is left untouched), or
// underflow (a pop from an empty deque changes nothing). A push into an
// empty deque always lands in slot zero, and popping the last element
// returns both pointers to slot zero. One request is handled at a time. The
// pointers and the store are updated on the accepting edge, and the store is
// read at the new front and rear on the next edge through its registered
// read port. The response is valid from the cycle after that and is held on
// the outputs until it is taken. The next request is accepted in the cycle
// after the response is taken.
module circular_deque (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          func,
  input  logic signed [cq_pkg::DATA_W-1:0]    value_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cq_pkg::DATA_W-1:0]    front_value,
  output logic signed [cq_pkg::DATA_W-1:0]    rear_value,
  output logic                                is_empty,
  output logic [1:0]                          status
);
  import cq_pkg::*;

  // Commands from the sequencing controller to the pointer and store logic.
  cmd_t cmd;

  // The controller owns the handshake on both channels and steps each
  // request through accept, store read and response.
  cq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the head and tail pointers, the empty flag, the
  // element store and the registered response fields.
  cq_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .value_in    (value_in),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .status      (status)
  );

endmodule

@@ src/cq_ctrl.sv @@
module cq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cq_pkg::cmd_t  cmd
);
  import cq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.take    = 1'b0;
    cmd.load_rd = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_READ: begin
        cmd.load_rd = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/cq_dpath.sv @@
module cq_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  cq_pkg::cmd_t                        cmd,
  input  logic [2:0]                          func,
  input  logic signed [cq_pkg::DATA_W-1:0]    value_in,
  output logic signed [cq_pkg::DATA_W-1:0]    front_value,
  output logic signed [cq_pkg::DATA_W-1:0]    rear_value,
  output logic                                is_empty,
  output logic [1:0]                          status
);
  import cq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] tail_next;
  logic             empty;
  logic             empty_next;
  status_t          st;
  status_t          st_next;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] tail_inc;
  logic [IDX_W-1:0] tail_dec;
  logic             full;

  logic signed [DATA_W-1:0] rd_front;
  logic signed [DATA_W-1:0] rd_rear;

  // Pointer moves wrap in both directions.
  assign head_inc = (head == IDX_LAST) ? IDX_ZERO : head + IDX_ONE;
  assign head_dec = (head == IDX_ZERO) ? IDX_LAST : head - IDX_ONE;
  assign tail_inc = (tail == IDX_LAST) ? IDX_ZERO : tail + IDX_ONE;
  assign tail_dec = (tail == IDX_ZERO) ? IDX_LAST : tail - IDX_ONE;
  assign full     = !empty && (tail_inc == head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    st_next    = STATUS_OK;
    wr_en      = 1'b0;
    wr_addr    = IDX_ZERO;
    unique case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (full) begin
          st_next = STATUS_OVERFLOW;
        end else if (empty) begin
          head_next  = IDX_ZERO;
          tail_next  = IDX_ZERO;
          empty_next = 1'b0;
          wr_en      = 1'b1;
          wr_addr    = IDX_ZERO;
        end else if (func == FUNC_PUSH_FRONT) begin
          head_next = head_dec;
          wr_en     = 1'b1;
          wr_addr   = head_dec;
        end else begin
          tail_next = tail_inc;
          wr_en     = 1'b1;
          wr_addr   = tail_inc;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (empty) begin
          st_next = STATUS_UNDERFLOW;
        end else if (head == tail) begin
          head_next  = IDX_ZERO;
          tail_next  = IDX_ZERO;
          empty_next = 1'b1;
        end else if (func == FUNC_POP_FRONT) begin
          head_next = head_inc;
        end else begin
          tail_next = tail_dec;
        end
      end
      default: begin
        st_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= IDX_ZERO;
      tail  <= IDX_ZERO;
      empty <= 1'b1;
      st    <= STATUS_OK;
    end else if (cmd.take) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      st    <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[wr_addr] <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      rd_front <= mem[head];
      rd_rear  <= mem[tail];
    end
  end

  assign front_value = empty ? EMPTY_VALUE : rd_front;
  assign rear_value  = empty ? EMPTY_VALUE : rd_rear;
  assign is_empty    = empty;
  assign status      = st;

endmodule
